### src/sector_cache_clock_directory_top_assert.svh
// Assertion macros for the sector cache clock directory.
// Needs clk and arst_n in the including scope; define ASSERT_OFF to drop the checks.
`ifndef SECTOR_CACHE_CLOCK_DIRECTORY_TOP_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_DIRECTORY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCD_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("scd invariant violated");
`define SCD_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scd implication violated");
`else
`define SCD_CHECK(lbl, expr)
`define SCD_IMPLY(lbl, ante, cons)
`endif
`endif

### src/scd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// sector cache clock directory. No dependencies.
`timescale 1ns / 1ps

package scd_pkg;
	localparam int ENTRIES      = 64;
	localparam int SECTOR_BYTES = 512;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int OFF_W        = $clog2(SECTOR_BYTES);
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int ADDR_W       = IDX_W + OFF_W;
	localparam int TAG_W        = 32;
	localparam int LEN_W        = 10;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_GRANT     = 2'd0,
		KIND_WRITEBACK = 2'd1,
		KIND_FILL      = 2'd2,
		KIND_CLEAN     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK_PRIME,
		ST_LOOK,
		ST_SWEEP,
		ST_WB_READ,
		ST_WB_EMIT,
		ST_FILL,
		ST_GRANT,
		ST_FL_PRIME,
		ST_FL_SCAN,
		ST_CLEAN
	} state_t;

	typedef struct packed {
		logic  load_in;
		logic  idx_clr;
		logic  adv;
		logic  take_hit;
		logic  take_free;
		logic  sweep_clr_ref;
		logic  take_victim;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
		logic  clr_dirty;
		logic  commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic tag_hit;
		logic cur_valid;
		logic cur_dirty;
		logic cur_last;
		logic hand_ref;
		logic hand_dirty;
		logic cnt_zero;
		logic cnt_one;
	} sts_t;
endpackage

### src/scd_ctrl.sv
// Controller state machine for the sector cache clock directory.
// Depends on scd_pkg; drives the datapath through cmd_t, watches sts_t.
`timescale 1ns / 1ps

module scd_ctrl import scd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	input  op_t    op,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.emit_kind = KIND_GRANT;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					case (op)
						OP_READ, OP_WRITE: begin
							cmd.idx_clr = 1'b1;
							state_nxt   = ST_LOOK_PRIME;
						end
						OP_FLUSH: begin
							if (sts.cnt_zero) begin
								state_nxt = ST_CLEAN;
							end else begin
								cmd.idx_clr = 1'b1;
								state_nxt   = ST_FL_PRIME;
							end
						end
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_LOOK_PRIME: begin
				cmd.adv   = 1'b1;
				state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				// valid entries always form a prefix, so the first invalid one ends the search
				if (sts.cur_valid && sts.tag_hit) begin
					cmd.take_hit = 1'b1;
					state_nxt    = ST_GRANT;
				end else if (!sts.cur_valid) begin
					cmd.take_free = 1'b1;
					state_nxt     = ST_FILL;
				end else if (sts.cur_last) begin
					state_nxt = ST_SWEEP;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (sts.hand_ref) begin
					cmd.sweep_clr_ref = 1'b1;
				end else begin
					cmd.take_victim = 1'b1;
					state_nxt = sts.hand_dirty ? ST_WB_READ : ST_FILL;
				end
			end
			ST_WB_READ: begin
				cmd.adv   = 1'b1;
				state_nxt = ST_WB_EMIT;
			end
			ST_WB_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_WRITEBACK;
					cmd.clr_dirty = 1'b1;
					state_nxt     = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FILL;
					state_nxt     = ST_GRANT;
				end
			end
			ST_GRANT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_GRANT;
					cmd.emit_last = 1'b1;
					cmd.commit    = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			ST_FL_PRIME: begin
				cmd.adv   = 1'b1;
				state_nxt = ST_FL_SCAN;
			end
			ST_FL_SCAN: begin
				if (sts.cur_dirty) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_WRITEBACK;
						cmd.emit_last = sts.cnt_one;
						cmd.clr_dirty = 1'b1;
						if (sts.cnt_one) begin
							state_nxt = ST_IDLE;
						end else begin
							cmd.adv = 1'b1;
						end
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_CLEAN: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_CLEAN;
					cmd.emit_last = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

### src/scd_datapath.sv
// Datapath of the sector cache clock directory: tag memory, entry flags,
// clock hand, dirty count and the result register. Depends on scd_pkg.
`timescale 1ns / 1ps
`include "sector_cache_clock_directory_top_assert.svh"

module scd_datapath import scd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [1:0]          in_op,
	input  logic [TAG_W-1:0]    in_sector,
	input  logic [OFF_W-1:0]    in_offset,
	input  logic [LEN_W-1:0]    in_length,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,
	output logic [7:0]          m_tuser,
	output logic                m_tlast,
	output sts_t                sts
);

	logic [TAG_W-1:0] tag_mem [ENTRIES];

	logic [1:0]         op_q;
	logic [TAG_W-1:0]   sector_q;
	logic [OFF_W-1:0]   offset_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   slot_q;
	logic               hit_q;
	logic [TAG_W-1:0]   tag_s1;
	logic [IDX_W-1:0]   tidx_s1;

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] dirty_q;
	logic [ENTRIES-1:0] ref_q;
	logic [IDX_W-1:0]   hand_q;
	logic [IDX_W-1:0]   hand_nxt;
	logic [CNT_W-1:0]   cnt_q;
	logic               set_dirty;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic               out_last_q;
	logic [IDX_W-1:0]   out_slot_q;
	logic [TAG_W-1:0]   out_sector_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [LEN_W-1:0]   out_len_q;
	logic               out_hit_q;

	logic [IDX_W-1:0]   r_slot;
	logic [TAG_W-1:0]   r_sector;
	logic [ADDR_W-1:0]  r_addr;
	logic [LEN_W-1:0]   r_len;
	logic               r_hit;

	assign hand_nxt  = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
	assign set_dirty = cmd.commit && (op_q == OP_WRITE) && !dirty_q[slot_q];

	// tag memory: one write port at commit, one registered read port on advance
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			tag_mem[slot_q] <= sector_q;
		end
		if (cmd.adv) begin
			tag_s1  <= tag_mem[idx_q];
			tidx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_op;
			sector_q <= in_sector;
			offset_q <= in_offset;
			len_q    <= in_length;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.take_victim) begin
			idx_q <= hand_q;
		end else if (cmd.adv) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.take_hit || cmd.take_free) begin
			slot_q <= tidx_s1;
		end else if (cmd.take_victim) begin
			slot_q <= hand_q;
		end
		if (cmd.load_in) begin
			hit_q <= 1'b0;
		end else if (cmd.take_hit) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			ref_q   <= '0;
			hand_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.sweep_clr_ref) begin
				ref_q[hand_q] <= 1'b0;
			end
			if (cmd.sweep_clr_ref || cmd.take_victim) begin
				hand_q <= hand_nxt;
			end
			if (cmd.clr_dirty) begin
				dirty_q[tidx_s1] <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.commit) begin
				valid_q[slot_q] <= 1'b1;
				ref_q[slot_q]   <= 1'b1;
				if (op_q == OP_WRITE) begin
					dirty_q[slot_q] <= 1'b1;
				end
			end
			if (set_dirty) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// pick the result fields for the word being emitted
	always_comb begin
		r_slot   = '0;
		r_sector = '0;
		r_addr   = '0;
		r_len    = '0;
		r_hit    = 1'b0;
		case (cmd.emit_kind)
			KIND_WRITEBACK: begin
				r_slot   = tidx_s1;
				r_sector = tag_s1;
				r_addr   = {tidx_s1, {OFF_W{1'b0}}};
			end
			KIND_FILL: begin
				r_slot   = slot_q;
				r_sector = sector_q;
				r_addr   = {slot_q, {OFF_W{1'b0}}};
			end
			KIND_GRANT: begin
				r_slot   = slot_q;
				r_sector = sector_q;
				r_addr   = {slot_q, offset_q};
				r_len    = len_q;
				r_hit    = hit_q;
			end
			default: begin
				r_slot = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q   <= cmd.emit_kind;
			out_last_q   <= cmd.emit_last;
			out_slot_q   <= r_slot;
			out_sector_q <= r_sector;
			out_addr_q   <= r_addr;
			out_len_q    <= r_len;
			out_hit_q    <= r_hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {6'd0, out_kind_q};
	assign m_tdata  = {out_hit_q, out_len_q, out_addr_q, out_sector_q, out_slot_q};

	assign sts.out_free   = !out_valid_q || m_tready;
	assign sts.tag_hit    = (tag_s1 == sector_q);
	assign sts.cur_valid  = valid_q[tidx_s1];
	assign sts.cur_dirty  = dirty_q[tidx_s1];
	assign sts.cur_last   = (tidx_s1 == LAST_IDX);
	assign sts.hand_ref   = ref_q[hand_q];
	assign sts.hand_dirty = dirty_q[hand_q];
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.cnt_one    = (cnt_q == CNT_W'(1));

	`SCD_CHECK(a_valid_prefix, ((valid_q + ENTRIES'(1)) & valid_q) == '0)
	`SCD_CHECK(a_dirty_needs_valid, (dirty_q & ~valid_q) == '0)
	`SCD_CHECK(a_dirty_count, $countones(dirty_q) == int'(cnt_q))
	`SCD_IMPLY(a_clean_only_empty, cmd.emit && cmd.emit_kind == KIND_CLEAN, cnt_q == '0)

endmodule

### src/sector_cache_clock_directory_top.sv
// Top level of the sector cache clock directory: joins controller and datapath.
// Depends on scd_pkg, scd_ctrl and scd_datapath.
`timescale 1ns / 1ps

// Usage:
// - Request channel s_*: one word per read, write or flush. s_tuser carries
//   the operation, s_tdata the sector, offset and length. Unused op code 3 is
//   taken and dropped without results.
// - Result channel m_*: writeback, fill, grant or nothing-dirty words, m_tlast
//   set on the final word of each request. m_tuser carries the result kind.
// - One request at a time: s_tready is high only while the engine is idle, but
//   the last result may still wait in the output register when the next
//   request is taken.
// - Lookup walks the tag memory one entry per cycle through its single read
//   port: a hit leads to its grant word, a miss to a fill word first. With
//   all slots in use, the clock sweep clears set reference flags from the hand
//   on and evicts the first clear entry; a dirty victim is written back first.
// - Flush primes the read port, then walks the entries up to the last dirty
//   one, one per cycle unless the result side stalls, sending each writeback
//   as its entry is examined; with nothing dirty it sends one nothing-dirty word.
// - Reset clears valid, dirty and reference flags, the hand and the output
//   register at once; no clearing pass is needed.
// - A stalled receiver holds the current word; the engine waits in place.
module sector_cache_clock_directory_top import scd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] sector, [40:32] sector_offset, [50:41] chunk_length, rest zero
	input  logic [55:0] s_tdata,
	// [1:0] op, rest ignored
	input  logic [7:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] slot, [37:6] disk_sector, [52:38] store_address,
	// [62:53] copy_length, [63] was_hit
	output logic [63:0] m_tdata,
	// [1:0] kind, rest zero
	output logic [7:0]  m_tuser,
	output logic        m_tlast
);

	cmd_t cmd;
	sts_t sts;

	scd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (op_t'(s_tuser[1:0])),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold request fields, walk tags, drive the result register
	scd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_op     (s_tuser[1:0]),
		.in_sector (s_tdata[31:0]),
		.in_offset (s_tdata[40:32]),
		.in_length (s_tdata[50:41]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.sts       (sts)
	);

endmodule

### bench/sector_cache_clock_directory_top_test.sv
// Self-checking bench for the sector cache clock directory top level.
// Needs scd_pkg and the RTL; predicts every result word from its own copy of the directory.
`timescale 1ns / 1ps

module sector_cache_clock_directory_top_test;
	import scd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 84;
	localparam int HOT_COUNT    = 40;
	localparam int PLAN_ROWS    = 17;

	// One result word as the directory hands it out.
	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  slot;
		logic [TAG_W-1:0]  sector;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              hit;
		logic              last;
	} word_t;

	// One row of the directed part; final_word is used only where typed is set.
	typedef struct {
		op_t              op;
		logic [TAG_W-1:0] sector;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] len;
		logic             typed;
		word_t            final_word;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        m_tlast;

	// Shadow directory: the state the block should hold after each accepted word.
	logic             in_use [ENTRIES];
	logic             dirty  [ENTRIES];
	logic             recent [ENTRIES];
	logic [TAG_W-1:0] tag    [ENTRIES];
	logic [IDX_W-1:0] hand;

	word_t pending_words[$];
	bit    calm = 1'b0;
	int    mismatches = 0;
	int    words_checked = 0;
	int    cycle_count = 0;
	int    requests = 0, flushes = 0, ignored_ops = 0;
	int    hits = 0, fills = 0, evictions = 0, writebacks = 0;

	request_row_t     plan [PLAN_ROWS];
	logic [TAG_W-1:0] hot_sectors [HOT_COUNT];

	sector_cache_clock_directory_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side about 9 percent of the time, never while calm.
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 9);
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d result words still owed", $realtime,
				pending_words.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic word_t make_word(kind_t k, logic [IDX_W-1:0] s, logic [TAG_W-1:0] sec,
			logic [OFF_W-1:0] off, logic [LEN_W-1:0] len, logic hit, logic last);
		word_t w;
		w.kind   = k;
		w.slot   = s;
		w.sector = sec;
		w.addr   = ADDR_W'(int'(s) * SECTOR_BYTES + int'(off));
		w.len    = len;
		w.hit    = hit;
		w.last   = last;
		return w;
	endfunction

	// Work out the words one accepted request causes and advance the shadow directory.
	// A typed row replaces the final word with the value written in the table.
	task automatic predict_directory_words(op_t op, logic [TAG_W-1:0] sec,
			logic [OFF_W-1:0] off, logic [LEN_W-1:0] len, logic typed, word_t typed_word);
		logic [IDX_W-1:0] way;
		logic             hit;
		logic             got_free;
		int               last_dirty;
		word_t            w;
		way = '0;
		hit = 1'b0;
		got_free = 1'b0;
		last_dirty = -1;
		case (op)
			OP_NONE: begin
				ignored_ops++;
			end
			OP_FLUSH: begin
				flushes++;
				for (int i = 0; i < ENTRIES; i++)
					if (in_use[i] && dirty[i])
						last_dirty = i;
				if (last_dirty < 0) begin
					w = make_word(KIND_CLEAN, '0, '0, '0, '0, 1'b0, 1'b1);
					pending_words.push_back(typed ? typed_word : w);
				end
				for (int i = 0; i <= last_dirty; i++) begin
					if (in_use[i] && dirty[i]) begin
						w = make_word(KIND_WRITEBACK, IDX_W'(i), tag[i], '0, '0, 1'b0,
							i == last_dirty);
						pending_words.push_back((typed && i == last_dirty) ? typed_word : w);
						dirty[i] = 1'b0;
						writebacks++;
					end
				end
			end
			default: begin
				// Lowest valid match wins.
				for (int i = 0; i < ENTRIES; i++)
					if (!hit && in_use[i] && tag[i] == sec) begin
						way = IDX_W'(i);
						hit = 1'b1;
					end
				if (hit) begin
					hits++;
				end else begin
					for (int i = 0; i < ENTRIES; i++)
						if (!got_free && !in_use[i]) begin
							way = IDX_W'(i);
							got_free = 1'b1;
						end
					if (!got_free) begin
						// Clock sweep: clear reference marks until one is already clear.
						while (recent[hand]) begin
							recent[hand] = 1'b0;
							hand = hand + 1'b1;
						end
						way = hand;
						hand = hand + 1'b1;
						evictions++;
						if (dirty[way]) begin
							pending_words.push_back(make_word(KIND_WRITEBACK, way, tag[way],
								'0, '0, 1'b0, 1'b0));
							dirty[way] = 1'b0;
							writebacks++;
						end
					end
					pending_words.push_back(make_word(KIND_FILL, way, sec, '0, '0, 1'b0, 1'b0));
					fills++;
				end
				w = make_word(KIND_GRANT, way, sec, off, len, hit, 1'b1);
				pending_words.push_back(typed ? typed_word : w);
				in_use[way] = 1'b1;
				recent[way] = 1'b1;
				tag[way] = sec;
				if (op == OP_WRITE)
					dirty[way] = 1'b1;
			end
		endcase
	endtask

	// Present one request word from a falling edge, hold it until taken, then
	// predict its results. Returns on the falling edge after the handshake.
	task automatic push_request(op_t op, logic [TAG_W-1:0] sec, logic [OFF_W-1:0] off,
			logic [LEN_W-1:0] len, logic typed, word_t typed_word);
		if (!calm && $urandom_range(0, 99) < 9) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = {6'($urandom), op};   // upper bits are don't-care for the block
		s_tdata  = {5'b0, len, off, sec};
		do @(posedge clk); while (!s_tready);
		requests++;
		predict_directory_words(op, sec, off, len, typed, typed_word);
		@(negedge clk);
	endtask

	// Compare every accepted result word against the oldest prediction.
	always @(posedge clk) begin : check_word
		word_t got;
		word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind   = kind_t'(m_tuser[1:0]);
			got.slot   = m_tdata[5:0];
			got.sector = m_tdata[37:6];
			got.addr   = m_tdata[52:38];
			got.len    = m_tdata[62:53];
			got.hit    = m_tdata[63];
			got.last   = m_tlast;
			words_checked++;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: unexpected word kind=%0d slot=%0d sector=%h", $realtime,
						got.kind, got.slot, got.sector);
			end else begin
				want = pending_words.pop_front();
				if (got !== want || m_tuser[7:2] !== 6'b0) begin
					mismatches++;
					if (mismatches <= 40) begin
						$display("%0t: mismatch exp kind=%0d slot=%0d sector=%h addr=%0d len=%0d hit=%b last=%b",
							$realtime, want.kind, want.slot, want.sector, want.addr,
							want.len, want.hit, want.last);
						$display("%0t:          got kind=%0d slot=%0d sector=%h addr=%0d len=%0d hit=%b last=%b tuser=%h",
							$realtime, got.kind, got.slot, got.sector, got.addr,
							got.len, got.hit, got.last, m_tuser);
					end
				end
			end
		end
	end

	initial begin : stimulus
		int    taken;
		int    pick;
		op_t   op;
		logic [TAG_W-1:0] sec;
		logic [LEN_W-1:0] len;
		word_t none_typed;
		taken = 0;
		none_typed = '0;

		for (int i = 0; i < ENTRIES; i++) begin
			in_use[i] = 1'b0;
			dirty[i]  = 1'b0;
			recent[i] = 1'b0;
			tag[i]    = '0;
		end
		hand = '0;
		for (int i = 0; i < HOT_COUNT; i++)
			hot_sectors[i] = $urandom;

		// Directed rows: empty directory, extreme sectors, offsets and lengths,
		// every op, flush with and without dirty entries, and overruns past the sector.
		plan[0]  = '{OP_FLUSH, 32'h0, 9'd0, 10'd0, 1'b1,
			'{KIND_CLEAN, 6'd0, 32'h0, 15'd0, 10'd0, 1'b0, 1'b1}};
		plan[1]  = '{OP_READ, 32'h0, 9'd0, 10'd0, 1'b1,
			'{KIND_GRANT, 6'd0, 32'h0, 15'd0, 10'd0, 1'b0, 1'b1}};
		plan[2]  = '{OP_WRITE, 32'hFFFF_FFFF, 9'd511, 10'd512, 1'b1,
			'{KIND_GRANT, 6'd1, 32'hFFFF_FFFF, 15'd1023, 10'd512, 1'b0, 1'b1}};
		plan[3]  = '{OP_READ, 32'hFFFF_FFFF, 9'd0, 10'd1, 1'b1,
			'{KIND_GRANT, 6'd1, 32'hFFFF_FFFF, 15'd512, 10'd1, 1'b1, 1'b1}};
		plan[4]  = '{OP_NONE, 32'h5A5A_5A5A, 9'd17, 10'd33, 1'b0, none_typed};
		plan[5]  = '{OP_FLUSH, 32'h0, 9'd0, 10'd0, 1'b1,
			'{KIND_WRITEBACK, 6'd1, 32'hFFFF_FFFF, 15'd512, 10'd0, 1'b0, 1'b1}};
		plan[6]  = '{OP_FLUSH, 32'hDEAD_BEEF, 9'd5, 10'd5, 1'b1,
			'{KIND_CLEAN, 6'd0, 32'h0, 15'd0, 10'd0, 1'b0, 1'b1}};
		plan[7]  = '{OP_WRITE, 32'h0, 9'd0, 10'd512, 1'b1,
			'{KIND_GRANT, 6'd0, 32'h0, 15'd0, 10'd512, 1'b1, 1'b1}};
		plan[8]  = '{OP_WRITE, 32'h8000_0000, 9'd256, 10'd256, 1'b1,
			'{KIND_GRANT, 6'd2, 32'h8000_0000, 15'd1280, 10'd256, 1'b0, 1'b1}};
		plan[9]  = '{OP_WRITE, 32'h7FFF_FFFF, 9'd255, 10'd257, 1'b1,
			'{KIND_GRANT, 6'd3, 32'h7FFF_FFFF, 15'd1791, 10'd257, 1'b0, 1'b1}};
		plan[10] = '{OP_READ, 32'h1, 9'd1, 10'd511, 1'b0, none_typed};
		plan[11] = '{OP_WRITE, 32'h1234_5678, 9'd300, 10'd400, 1'b0, none_typed};
		plan[12] = '{OP_FLUSH, 32'h0, 9'd0, 10'd0, 1'b0, none_typed};
		plan[13] = '{OP_READ, 32'h0, 9'd511, 10'd0, 1'b0, none_typed};
		plan[14] = '{OP_NONE, 32'h0, 9'd0, 10'd0, 1'b0, none_typed};
		plan[15] = '{OP_READ, 32'hAAAA_AAAA, 9'd170, 10'd341, 1'b0, none_typed};
		plan[16] = '{OP_WRITE, 32'h5555_5555, 9'd341, 10'd170, 1'b0, none_typed};

		// Hold reset, then release it on a falling edge.
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < PLAN_ROWS; r++)
			push_request(plan[r].op, plan[r].sector, plan[r].offset, plan[r].len,
				plan[r].typed, plan[r].final_word);

		// Random part: accesses split between a small hot set and cold sectors, with
		// enough misses to fill the directory so the clock sweeps and evicts dirty
		// victims; some flushes and dropped op codes mixed in. Dropped ops do not
		// count toward the total.
		while (taken < RANDOM_ITEMS) begin
			calm = (taken >= 35 && taken < 65);
			if (taken == 65) begin
				// Let the block drain completely before going on.
				s_tvalid = 1'b0;
				while (pending_words.size() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			sec = ($urandom_range(0, 99) < 40) ? hot_sectors[$urandom_range(0, HOT_COUNT - 1)]
				: $urandom;
			len = ($urandom_range(0, 19) == 0) ? 10'd512 : LEN_W'($urandom_range(0, 512));
			if (pick < 10)
				op = OP_FLUSH;
			else if (pick < 14)
				op = OP_NONE;
			else
				op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			push_request(op, sec, OFF_W'($urandom_range(0, 511)), len, 1'b0, none_typed);
			if (op != OP_NONE)
				taken++;
		end
		s_tvalid = 1'b0;
		calm = 1'b0;

		// Drain, then watch a while longer for stray words.
		while (pending_words.size() != 0) @(posedge clk);
		repeat (2 * ENTRIES + 16) @(posedge clk);

		$display("Covered %0d requests (%0d flushes, %0d dropped op codes), %0d words checked.",
			requests, flushes, ignored_ops, words_checked);
		$display("Directory saw %0d hits, %0d fills, %0d clock evictions, %0d writebacks.",
			hits, fills, evictions, writebacks);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### sector_cache_clock_directory_top.f
+incdir+src
src/scd_pkg.sv
src/scd_ctrl.sv
src/scd_datapath.sv
src/sector_cache_clock_directory_top.sv
bench/sector_cache_clock_directory_top_test.sv
